>>> sv/lzbp_pkg.sv
// Shared types and constants for the byte-pair LZ77 record decompressor.
package lzbp_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 2048;

    localparam logic [15:0] LIMIT_RESET = 16'd6000;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] HIGH_FLIP  = 8'h80;
    localparam logic [7:0] PAIR_LOW   = 8'd128;
    localparam logic [7:0] SPACE_LOW  = 8'd192;
    localparam logic [7:0] RUN_LOW    = 8'd1;
    localparam logic [7:0] RUN_HIGH   = 8'd8;
    localparam logic [3:0] COPY_BIAS  = 4'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_BAD_DIST  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_SPACE = 6'b000100,
        S_ONE   = 6'b001000,
        S_COPY  = 6'b010000,
        S_MARK  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        PH_CODE = 3'b001,
        PH_LIT  = 3'b010,
        PH_PAIR = 3'b100
    } phase_t;

endpackage

>>> sv/lzbp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lzbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/lz77_byte_pair_decompressor.sv
// Top level of the byte-pair LZ77 record decompressor with its history RAM.
//
//   Channel   Signals                                   Direction  Handshake
//   --------  ----------------------------------------  ---------  ---------------
//   input     in_byte, last_of_record                   in         in_valid/in_ready
//   output    out_byte, byte_valid, end_of_record,      out        out_valid/out_ready
//             status, record_length
//   config    cfg_wdata (output_limit)                  in         cfg_we, no wait
//
// An input word is first taken in while the decoder is idle and then decoded; each result
// word it causes is then launched in turn, and a back-reference of ten bytes is the longest.
// The history RAM writes one decompressed byte per cycle while the output register can load.
// Reset clears the control state and sets the limit to 6000; the history RAM is not
// cleared, since a copy only reads bytes already written in the same record.
// A stalled output holds its word in the output register; the decoder stops in place
// until that register frees up, and the input is only taken while the decoder is idle.
module lz77_byte_pair_decompressor
    import lzbp_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        last_of_record,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        end_of_record,
    output logic [1:0]  status,
    output logic [15:0] record_length,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    // Control state.
    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [3:0]    lit_left_reg, lit_left_next;
    logic [5:0]    pend_reg, pend_next;
    logic [1:0]    err_reg, err_next;
    logic [15:0]   count_reg, count_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [15:0]   limit_reg;
    logic          last_reg, last_next;
    logic          mark_reg, mark_next;
    logic [1:0]    mark_status_reg, mark_status_next;
    logic [3:0]    copy_left_reg, copy_left_next;
    logic          fwd_reg, fwd_next;
    logic          out_valid_reg, out_valid_next;

    // Payload state.
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    data_reg, data_next;
    logic [AW-1:0] src_reg, src_next;
    logic          dist_one_reg, dist_one_next;
    logic [7:0]    hist_byte_reg, hist_byte_next;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          end_reg;
    logic [1:0]    status_reg;
    logic [15:0]   length_reg;

    // History RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Result word launched into the output register this cycle.
    logic          emit;
    logic [7:0]    emit_byte;
    logic          emit_valid;
    logic          emit_end;
    logic [1:0]    emit_status;
    logic [15:0]   emit_length;

    logic          can_load;

    lzbp_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        logic [10:0]   pair_dist;
        logic [3:0]    pair_len;
        logic [16:0]   cnt_wide;
        logic [16:0]   lim_wide;
        logic          fit_one;
        logic          fit_two;
        logic          fit_run;
        logic          fit_len;
        logic [AW-1:0] wp_inc;
        logic [AW-1:0] src_inc;
        logic [AW-1:0] src_first;
        logic [7:0]    copy_byte;
        logic          go_one;
        logic          go_space;
        logic          go_copy;
        logic [1:0]    fresh_err;
        phase_t        phase_after;
        logic          finish;

        state_next       = state_reg;
        phase_next       = phase_reg;
        lit_left_next    = lit_left_reg;
        pend_next        = pend_reg;
        err_next         = err_reg;
        count_next       = count_reg;
        wp_next          = wp_reg;
        last_next        = last_reg;
        mark_next        = mark_reg;
        mark_status_next = mark_status_reg;
        copy_left_next   = copy_left_reg;
        fwd_next         = fwd_reg;
        byte_next        = byte_reg;
        data_next        = data_reg;
        src_next         = src_reg;
        dist_one_next    = dist_one_reg;
        hist_byte_next   = hist_byte_reg;

        emit        = 1'b0;
        emit_byte   = 8'h00;
        emit_valid  = 1'b0;
        emit_end    = 1'b0;
        emit_status = ST_OK;
        emit_length = count_reg;
        finish      = 1'b0;

        go_one      = 1'b0;
        go_space    = 1'b0;
        go_copy     = 1'b0;
        fresh_err   = ST_OK;
        phase_after = phase_reg;

        // The pair's distance sits in bits 13..3, its length code in bits 2..0.
        pair_dist = {pend_reg, byte_reg[7:3]};
        pair_len  = {1'b0, byte_reg[2:0]} + COPY_BIAS;

        cnt_wide = {1'b0, count_reg};
        lim_wide = {1'b0, limit_reg};
        fit_one  = (cnt_wide + 17'd1) <= lim_wide;
        fit_two  = (cnt_wide + 17'd2) <= lim_wide;
        fit_run  = (cnt_wide + 17'(byte_reg[3:0])) <= lim_wide;
        fit_len  = (cnt_wide + 17'(pair_len)) <= lim_wide;

        wp_inc  = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        src_inc = (src_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : src_reg + AW'(1);
        if ({1'b0, wp_reg} >= (AW+1)'(pair_dist))
        begin
            src_first = wp_reg - AW'(pair_dist);
        end
        else
        begin
            src_first = AW'({1'b0, wp_reg} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(pair_dist));
        end

        // With a distance of one every copied byte repeats the one just written.
        copy_byte = fwd_reg ? hist_byte_reg : ram_rdata;

        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_re    = 1'b0;
        ram_raddr = src_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_byte;
                    last_next  = last_of_record;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                mark_next        = 1'b0;
                mark_status_next = ST_OK;
                if (err_reg != ST_OK)
                begin
                    // Latched error: silent until the record's final word.
                    if (last_reg)
                    begin
                        mark_next        = 1'b1;
                        mark_status_next = err_reg;
                        state_next       = S_MARK;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_LIT:
                        begin
                            go_one        = 1'b1;
                            data_next     = byte_reg;
                            lit_left_next = lit_left_reg - 4'd1;
                            if (lit_left_reg == 4'd1)
                            begin
                                phase_after = PH_CODE;
                            end
                        end
                        PH_PAIR:
                        begin
                            phase_after = PH_CODE;
                            pend_next   = '0;
                            if (pair_dist == '0 || 16'(pair_dist) > count_reg)
                            begin
                                fresh_err = ST_BAD_DIST;
                            end
                            else if (!fit_len)
                            begin
                                fresh_err = ST_OVERFLOW;
                            end
                            else
                            begin
                                go_copy = 1'b1;
                            end
                        end
                        PH_CODE:
                        begin
                            if (byte_reg >= RUN_LOW && byte_reg <= RUN_HIGH)
                            begin
                                // A run is checked as a whole when its count arrives.
                                if (!fit_run)
                                begin
                                    fresh_err = ST_OVERFLOW;
                                end
                                else
                                begin
                                    lit_left_next = byte_reg[3:0];
                                    phase_after   = PH_LIT;
                                end
                            end
                            else if (byte_reg < PAIR_LOW)
                            begin
                                if (!fit_one)
                                begin
                                    fresh_err = ST_OVERFLOW;
                                end
                                else
                                begin
                                    go_one    = 1'b1;
                                    data_next = byte_reg;
                                end
                            end
                            else if (byte_reg >= SPACE_LOW)
                            begin
                                if (!fit_two)
                                begin
                                    fresh_err = ST_OVERFLOW;
                                end
                                else
                                begin
                                    go_space  = 1'b1;
                                    data_next = byte_reg ^ HIGH_FLIP;
                                end
                            end
                            else
                            begin
                                pend_next   = byte_reg[5:0];
                                phase_after = PH_PAIR;
                            end
                        end
                        default:
                        begin
                            phase_after = PH_CODE;
                        end
                    endcase

                    if (last_reg && fresh_err == ST_OK && phase_after != PH_CODE)
                    begin
                        fresh_err = ST_TRUNCATED;
                    end
                    phase_next = phase_after;

                    if (fresh_err != ST_OK)
                    begin
                        err_next         = fresh_err;
                        mark_next        = 1'b1;
                        mark_status_next = fresh_err;
                    end
                    else if (last_reg && !go_one && !go_space && !go_copy)
                    begin
                        // Final word without data still closes the record.
                        mark_next        = 1'b1;
                        mark_status_next = ST_OK;
                    end

                    if (go_space)
                    begin
                        state_next = S_SPACE;
                    end
                    else if (go_one)
                    begin
                        state_next = S_ONE;
                    end
                    else if (go_copy)
                    begin
                        // Fetch the first source byte now; the RAM returns it next cycle.
                        ram_re         = 1'b1;
                        ram_raddr      = src_first;
                        src_next       = src_first;
                        copy_left_next = pair_len;
                        dist_one_next  = (pair_dist == 11'd1);
                        fwd_next       = 1'b0;
                        state_next     = S_COPY;
                    end
                    else if (fresh_err != ST_OK || (last_reg && !go_one))
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end

            S_SPACE:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    emit_byte  = SPACE_CHAR;
                    emit_valid = 1'b1;
                    state_next = S_ONE;
                end
            end

            S_ONE:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    emit_byte  = data_reg;
                    emit_valid = 1'b1;
                    emit_end   = last_reg && !mark_reg;
                    if (mark_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end

            S_COPY:
            begin
                if (can_load)
                begin
                    emit           = 1'b1;
                    emit_byte      = copy_byte;
                    emit_valid     = 1'b1;
                    hist_byte_next = copy_byte;
                    copy_left_next = copy_left_reg - 4'd1;
                    if (copy_left_reg == 4'd1)
                    begin
                        emit_end = last_reg;
                        finish   = 1'b1;
                    end
                    else
                    begin
                        // The next source is never the byte written now, except at
                        // distance one, which is served from hist_byte_reg.
                        ram_re    = !dist_one_reg;
                        ram_raddr = src_inc;
                        src_next  = src_inc;
                        fwd_next  = dist_one_reg;
                    end
                end
            end

            S_MARK:
            begin
                if (can_load)
                begin
                    emit        = 1'b1;
                    emit_byte   = 8'h00;
                    emit_valid  = 1'b0;
                    emit_status = mark_status_reg;
                    emit_end    = last_reg;
                    finish      = 1'b1;
                end
            end

            default:
            begin
                finish = 1'b1;
            end
        endcase

        // Every data byte goes to the history and advances the counts.
        if (emit && emit_valid)
        begin
            ram_we      = 1'b1;
            wp_next     = wp_inc;
            count_next  = count_reg + 16'd1;
            emit_length = count_reg + 16'd1;
        end
        ram_wdata = emit_byte;

        if (finish)
        begin
            state_next = S_IDLE;
            if (last_reg)
            begin
                wp_next       = '0;
                count_next    = '0;
                phase_next    = PH_CODE;
                lit_left_next = '0;
                pend_next     = '0;
                err_next      = ST_OK;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_CODE;
            lit_left_reg    <= '0;
            pend_reg        <= '0;
            err_reg         <= ST_OK;
            count_reg       <= '0;
            wp_reg          <= '0;
            limit_reg       <= LIMIT_RESET;
            last_reg        <= 1'b0;
            mark_reg        <= 1'b0;
            mark_status_reg <= ST_OK;
            copy_left_reg   <= '0;
            fwd_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            lit_left_reg    <= lit_left_next;
            pend_reg        <= pend_next;
            err_reg         <= err_next;
            count_reg       <= count_next;
            wp_reg          <= wp_next;
            last_reg        <= last_next;
            mark_reg        <= mark_next;
            mark_status_reg <= mark_status_next;
            copy_left_reg   <= copy_left_next;
            fwd_reg         <= fwd_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        data_reg      <= data_next;
        src_reg       <= src_next;
        dist_one_reg  <= dist_one_next;
        hist_byte_reg <= hist_byte_next;
        if (emit)
        begin
            out_byte_reg   <= emit_byte;
            byte_valid_reg <= emit_valid;
            end_reg        <= emit_end;
            status_reg     <= emit_status;
            length_reg     <= emit_length;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign end_of_record = end_reg;
    assign status        = status_reg;
    assign record_length = length_reg;

`ifndef ASSERT_OFF
    a_data_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> status == ST_OK)
        else $error("data word carries an error status");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00)
        else $error("marker word carries a nonzero byte");

    a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> copy_left_reg != 4'd0)
        else $error("copy running with nothing left to copy");

    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && err_reg != ST_OK |-> phase_reg == PH_CODE)
        else $error("latched error left the decoder inside a code");
`endif

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the byte-pair LZ77 record decompressor with a built-in decoder model.
module tb_top
    import lzbp_pkg::*;
();

    localparam int unsigned WIN_DEPTH     = HISTORY_DEPTH_DEF;
    localparam int unsigned WIN_BITS      = $clog2(WIN_DEPTH);
    localparam int unsigned MAX_DIST      = 2047;
    localparam int unsigned MAX_COPY      = 10;
    localparam int unsigned LONG_BYTES    = 800;
    localparam int unsigned SETTLE_CYCLES = 30;
    localparam int unsigned STALL_LIMIT   = 2000;

    // One compressed word as the driver presents it.
    typedef struct {
        logic [7:0] code;
        logic       fin;
    } comp_word_t;

    // One decompressed word as the block should deliver it.
    typedef struct {
        logic [7:0]  data;
        logic        is_data;
        logic        eor;
        logic [1:0]  status;
        logic [15:0] total;
    } plain_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = '0;
    logic        last_of_record = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_record;
    logic [1:0]  status;
    logic [15:0] record_length;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = LIMIT_RESET;

    // Decoder model state: the sliding window and the per-record bookkeeping.
    logic [7:0]          win_mem [WIN_DEPTH];
    logic [WIN_BITS-1:0] win_ptr = '0;
    logic [15:0]         out_total = '0;
    phase_t              dec_state = PH_CODE;
    logic [3:0]          run_left = '0;
    logic [5:0]          pair_hi = '0;
    logic [1:0]          sticky_err = ST_OK;
    logic [15:0]         byte_cap = LIMIT_RESET;

    plain_word_t step_words[$];
    plain_word_t expected_words[$];
    comp_word_t  pending_words[$];
    comp_word_t  next_word;

    int unsigned words_queued = 0;
    int unsigned in_idle_pct = 0;
    int unsigned out_idle_pct = 0;
    int unsigned stall_cycles = 0;
    int unsigned fail_count = 0;

    lz77_byte_pair_decompressor i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .last_of_record (last_of_record),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .end_of_record  (end_of_record),
        .status         (status),
        .record_length  (record_length),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic void push_result(input logic [7:0] data, input logic is_data,
                                        input logic [1:0] st);
        plain_word_t w;
        w.data    = data;
        w.is_data = is_data;
        w.eor     = 1'b0;
        w.status  = st;
        w.total   = out_total;
        step_words.push_back(w);
    endfunction

    function automatic void push_data(input logic [7:0] data);
        win_mem[win_ptr] = data;
        win_ptr = win_ptr + 1'b1;
        out_total = out_total + 1'b1;
        push_result(data, 1'b1, ST_OK);
    endfunction

    // An error leaves one bare marker behind and holds until the record ends.
    function automatic void raise_error(input logic [1:0] st);
        sticky_err = st;
        push_result(8'h00, 1'b0, st);
    endfunction

    function automatic logic has_room(input int unsigned n);
        return (32'(out_total) + n) <= 32'(byte_cap);
    endfunction

    // Works out every word that one accepted compressed word should cause.
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [13:0] code;
        int unsigned gap;
        int unsigned len;
        step_words.delete();
        if (sticky_err == ST_OK)
        begin
            case (dec_state)
                PH_LIT:
                begin
                    push_data(b);
                    run_left = run_left - 1'b1;
                    if (run_left == 0)
                        dec_state = PH_CODE;
                end
                PH_PAIR:
                begin
                    code = {pair_hi, b};
                    gap = code[13:3];
                    len = code[2:0] + COPY_BIAS;
                    dec_state = PH_CODE;
                    pair_hi = '0;
                    if (gap == 0 || gap > out_total)
                        raise_error(ST_BAD_DIST);
                    else if (!has_room(len))
                        raise_error(ST_OVERFLOW);
                    else
                        repeat (len) push_data(win_mem[win_ptr - WIN_BITS'(gap)]);
                end
                PH_CODE:
                begin
                    if (b >= RUN_LOW && b <= RUN_HIGH)
                    begin
                        // A literal run is checked against the limit as a whole.
                        if (!has_room(b))
                            raise_error(ST_OVERFLOW);
                        else
                        begin
                            run_left = b[3:0];
                            dec_state = PH_LIT;
                        end
                    end
                    else if (b < PAIR_LOW)
                    begin
                        if (!has_room(1))
                            raise_error(ST_OVERFLOW);
                        else
                            push_data(b);
                    end
                    else if (b >= SPACE_LOW)
                    begin
                        if (!has_room(2))
                            raise_error(ST_OVERFLOW);
                        else
                        begin
                            push_data(SPACE_CHAR);
                            push_data(b ^ HIGH_FLIP);
                        end
                    end
                    else
                    begin
                        pair_hi = b[5:0];
                        dec_state = PH_PAIR;
                    end
                end
            endcase
            if (fin && sticky_err == ST_OK && dec_state != PH_CODE)
                raise_error(ST_TRUNCATED);
        end
        if (fin)
        begin
            if (step_words.size() == 0)
                push_result(8'h00, 1'b0, sticky_err);
            step_words[step_words.size() - 1].eor = 1'b1;
            win_ptr = '0;
            out_total = '0;
            dec_state = PH_CODE;
            run_left = '0;
            pair_hi = '0;
            sticky_err = ST_OK;
        end
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void add_word(input logic [7:0] code, input logic fin);
        comp_word_t w;
        w.code = code;
        w.fin  = fin;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    // A back-reference travels as two words: a marker byte with the top six
    // bits of the code, then the low eight bits.
    function automatic void add_pair(input int unsigned gap, input int unsigned len,
                                     input logic fin);
        logic [13:0] code;
        code = {11'(gap), 3'(len - COPY_BIAS)};
        add_word(PAIR_LOW | {2'b00, code[13:8]}, 1'b0);
        add_word(code[7:0], fin);
    endfunction

    // Mostly well-formed tokens with random content, with a little noise,
    // bad distances and records cut off inside a code.
    function automatic void build_record(input int unsigned tokens);
        int unsigned made;
        int unsigned pick;
        int unsigned cnt;
        int unsigned len;
        int unsigned span;
        made = 0;
        repeat (tokens)
        begin
            pick = $urandom_range(0, 99);
            len = $urandom_range(COPY_BIAS, MAX_COPY);
            span = (made > MAX_DIST) ? MAX_DIST : made;
            if (pick < 20)
            begin
                // The value RUN_HIGH stands in for a zero byte here.
                cnt = $urandom_range(RUN_HIGH, 127);
                add_word((cnt == RUN_HIGH) ? 8'h00 : 8'(cnt), 1'b0);
                made += 1;
            end
            else if (pick < 35)
            begin
                add_word(8'($urandom_range(SPACE_LOW, 255)), 1'b0);
                made += 2;
            end
            else if (pick < 55)
            begin
                cnt = $urandom_range(RUN_LOW, RUN_HIGH);
                add_word(8'(cnt), 1'b0);
                repeat (cnt) add_word(8'($urandom_range(0, 255)), 1'b0);
                made += cnt;
            end
            else if (pick < 88 && made > 0)
            begin
                add_pair($urandom_range(1, span), len, 1'b0);
                made += len;
            end
            else if (pick < 94)
                add_pair((made >= MAX_DIST || pick % 2 == 0) ? 0 :
                         $urandom_range(made + 1, MAX_DIST), len, 1'b0);
            else
                add_word(8'($urandom_range(0, 255)), 1'b0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 4)
            add_word(RUN_LOW + 8'($urandom_range(0, 7)), 1'b1);
        else if (pick < 8)
            add_word(PAIR_LOW | 8'($urandom_range(0, 63)), 1'b1);
        else if (pick < 12)
        begin
            // The record ends while literal bytes are still owed.
            cnt = $urandom_range(2, RUN_HIGH);
            add_word(8'(cnt), 1'b0);
            repeat (cnt - 1) add_word(8'($urandom_range(0, 255)), 1'b0);
            pending_words[pending_words.size() - 1].fin = 1'b1;
        end
        else
            pending_words[pending_words.size() - 1].fin = 1'b1;
    endfunction

    // Waits until every word has been taken and every result has come back,
    // then lets the block settle for words that cause no result.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_limit(input logic [15:0] cap);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        byte_cap = cap;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued words and feeds the model on each handshake.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                decode_byte(in_byte, last_of_record);
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= in_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    in_byte <= next_word.code;
                    last_of_record <= next_word.fin;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each delivered word with the oldest expectation.
    // ------------------------------------------------------------------

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_word();
        plain_word_t want;
        if (expected_words.size() == 0)
        begin
            $error("output word %0h arrived with nothing expected", out_byte);
            fail_count++;
        end
        else
        begin
            want = expected_words.pop_front();
            cmp_field("out_byte", want.data, out_byte);
            cmp_field("byte_valid", want.is_data, byte_valid);
            cmp_field("end_of_record", want.eor, end_of_record);
            cmp_field("status", want.status, status);
            cmp_field("record_length", want.total, record_length);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                check_word();
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // The watchdog ends a run in which no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        int unsigned mark;
        int unsigned made;
        int unsigned len;
        int unsigned span;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Slow receiver, mostly busy sender, default limit.
        in_idle_pct = 15;
        out_idle_pct = 76;
        set_limit(LIMIT_RESET);

        // A clean record touching plain bytes at both ends of their range,
        // a one-byte literal run, space pairs and two back-references.
        add_word(8'h00, 1'b0);
        add_word(8'h7F, 1'b0);
        add_word(8'h09, 1'b0);
        add_word(RUN_LOW, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(SPACE_LOW, 1'b0);
        add_word(8'hFF, 1'b0);
        add_pair(1, COPY_BIAS, 1'b0);
        add_pair(11, MAX_COPY, 1'b0);
        add_word(8'h41, 1'b1);
        // A distance of zero, after which words are ignored until the end.
        add_pair(0, COPY_BIAS, 1'b0);
        add_word(8'h41, 1'b0);
        add_word(8'h42, 1'b1);
        // A distance one past the bytes produced, on the final word.
        add_word(8'h41, 1'b0);
        add_pair(2, COPY_BIAS, 1'b1);
        // Records that end on a count byte and on the first byte of a pair.
        add_word(RUN_HIGH, 1'b1);
        add_word(SPACE_LOW - 8'd1, 1'b1);

        // The sender holds off here until every result is back.
        drain();
        mark = words_queued;
        while (words_queued - mark < 50)
            build_record($urandom_range(2, 14));
        drain();

        // Slow sender, fast receiver, and tight limits.
        in_idle_pct = 76;
        out_idle_pct = 15;
        set_limit(16'd1);
        add_word(8'h41, 1'b1);
        add_word(8'h41, 1'b0);
        add_word(8'h42, 1'b1);
        add_word(SPACE_LOW | 8'h01, 1'b1);
        drain();
        set_limit(16'($urandom_range(20, 120)));
        mark = words_queued;
        while (words_queued - mark < 50)
            build_record($urandom_range(2, 14));
        drain();

        // No idling; one long record made mostly of long back-references,
        // then a few short records.
        in_idle_pct = 0;
        out_idle_pct = 0;
        set_limit(16'd65535);
        made = 0;
        repeat (4)
        begin
            add_word(8'($urandom_range(9, 127)), 1'b0);
            made++;
        end
        while (made < LONG_BYTES)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(COPY_BIAS, MAX_COPY) : MAX_COPY;
            span = (made > MAX_DIST) ? MAX_DIST : made;
            add_pair(($urandom_range(0, 3) == 0) ? span : $urandom_range(1, span), len, 1'b0);
            made += len;
        end
        add_word(8'h2E, 1'b1);
        mark = words_queued;
        while (words_queued - mark < 20)
            build_record($urandom_range(2, 10));
        drain();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/lzbp_pkg.sv
sv/lzbp_ram.sv
sv/lz77_byte_pair_decompressor.sv
verif/tb_top.sv
